// ===== hdl/pfsq_pkg.sv =====
// ----------------------------------------------------------------------------
// pfsq_pkg
// Types and constants for squaring modulo 2^130-5 with 44/43/43-bit limbs.
// ----------------------------------------------------------------------------
package pfsq_pkg;

   localparam int L0_W    = 44;  // limb 0 width
   localparam int L12_W   = 43;  // limb 1 and limb 2 width
   localparam int L2O_W   = 44;  // output limb 2 width, holds one extra unit
   localparam int OP_W    = 48;  // multiplier operand width (20 * a2 fits)
   localparam int HALF_W  = 24;  // operand split for partial products
   localparam int COL_W   = 92;  // column sum width
   localparam int CARRY_W = 48;  // top column carry width
   localparam int FOLD_W  = 52;  // limb 0 plus 5 * carry
   localparam int NMUL    = 6;   // limb products per item
   localparam int NSTG    = 8;   // pipeline stages

   typedef struct packed {
      logic [L0_W-1:0]  in_limb0;
      logic [L12_W-1:0] in_limb1;
      logic [L12_W-1:0] in_limb2;
   } req_type;

   typedef struct packed {
      logic [L0_W-1:0]  sq_limb0;
      logic [L12_W-1:0] sq_limb1;
      logic [L2O_W-1:0] sq_limb2;
   } rsp_type;

   typedef struct packed {
      logic pp_en;   // load partial products
      logic sum_en;  // load combined product
   } mul_ctl_type;

endpackage

// ===== hdl/poly1305_field_square_unit.sv =====
// ----------------------------------------------------------------------------
// poly1305_field_square_unit
// Squares a three-limb element modulo 2^130-5, weakly reduced output.
// Pipeline: eight register stages (input, partial products, products, columns,
//   two carry steps, fold, output).
// Throughput: one item per cycle; a stage holds only while the next is full
//   and stalled, bubbles are squeezed out.
// Reset clears all stage valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
module poly1305_field_square_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  pfsq_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output pfsq_pkg::rsp_type rsp_data
);

   localparam int NSTG = pfsq_pkg::NSTG;
   localparam int NMUL = pfsq_pkg::NMUL;
   localparam int OPW  = pfsq_pkg::OP_W;
   localparam int CW   = pfsq_pkg::COL_W;
   localparam int L0W  = pfsq_pkg::L0_W;
   localparam int L12W = pfsq_pkg::L12_W;
   localparam int L2OW = pfsq_pkg::L2O_W;
   localparam int CRW  = pfsq_pkg::CARRY_W;
   localparam int FW   = pfsq_pkg::FOLD_W;

   logic [NSTG-1:0] stg_valid_ff, stg_valid_in, stg_en;

   // stage control
   always_comb begin
      stg_en[NSTG-1] = !stg_valid_ff[NSTG-1] || !rsp_stall;
      for (int i = NSTG - 2; i >= 0; i--) begin
         stg_en[i] = !stg_valid_ff[i] || stg_en[i+1];
      end
   end

   assign stg_valid_in = {stg_valid_ff[NSTG-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= '0;
      end else begin
         for (int i = 0; i < NSTG; i++) begin
            if (stg_en[i]) begin
               stg_valid_ff[i] <= stg_valid_in[i];
            end
         end
      end
   end

   assign req_stall = !stg_en[0];
   assign rsp_valid = stg_valid_ff[NSTG-1];

   // stage 0: input register
   pfsq_pkg::req_type in_ff;

   always_ff @(posedge clock) begin
      if (stg_en[0]) begin
         in_ff <= req_data;
      end
   end

   // operand multiples: 2*a0, 2*a1, 5*a2, 20*a2
   logic [OPW-1:0] a0_w, a1_w, a2_w, two_a0, two_a1, five_a2, twenty_a2;
   logic [OPW-1:0] mul_a [NMUL];
   logic [OPW-1:0] mul_b [NMUL];
   logic [CW-1:0]  prod  [NMUL];

   always_comb begin
      a0_w      = OPW'(in_ff.in_limb0);
      a1_w      = OPW'(in_ff.in_limb1);
      a2_w      = OPW'(in_ff.in_limb2);
      two_a0    = a0_w << 1;
      two_a1    = a1_w << 1;
      five_a2   = (a2_w << 2) + a2_w;
      twenty_a2 = five_a2 << 2;
      mul_a[0] = a0_w;    mul_b[0] = a0_w;
      mul_a[1] = a1_w;    mul_b[1] = twenty_a2;
      mul_a[2] = two_a0;  mul_b[2] = a1_w;
      mul_a[3] = a2_w;    mul_b[3] = five_a2;
      mul_a[4] = two_a0;  mul_b[4] = a2_w;
      mul_a[5] = a1_w;    mul_b[5] = two_a1;
   end

   // stages 1 and 2: limb products
   pfsq_pkg::mul_ctl_type mul_ctl;

   assign mul_ctl.pp_en  = stg_en[1];
   assign mul_ctl.sum_en = stg_en[2];

   for (genvar g = 0; g < NMUL; g++) begin : g_mul
      pfsq_mul u_mul (
         .clock (clock),
         .ctl   (mul_ctl),
         .op_a  (mul_a[g]),
         .op_b  (mul_b[g]),
         .prod  (prod[g])
      );
   end

   // stage 3: column sums
   logic [CW-1:0] col0_ff, col1_ff, col2_ff;

   always_ff @(posedge clock) begin
      if (stg_en[3]) begin
         col0_ff <= prod[0] + prod[1];
         col1_ff <= prod[2] + prod[3];
         col2_ff <= prod[4] + prod[5];
      end
   end

   // stage 4: carry column 0 into column 1
   logic [L0W-1:0] h0_s4_ff;
   logic [CW-1:0]  c1a_ff, c2p_ff;

   always_ff @(posedge clock) begin
      if (stg_en[4]) begin
         h0_s4_ff <= col0_ff[L0W-1:0];
         c1a_ff   <= col1_ff + (col0_ff >> L0W);
         c2p_ff   <= col2_ff;
      end
   end

   // stage 5: carry column 1 into column 2, split off top carry
   logic [CW-1:0]   c2b;
   logic [L0W-1:0]  h0_s5_ff;
   logic [L12W-1:0] h1_s5_ff, h2_s5_ff;
   logic [CRW-1:0]  carry_ff;

   assign c2b = c2p_ff + (c1a_ff >> L12W);

   always_ff @(posedge clock) begin
      if (stg_en[5]) begin
         h0_s5_ff <= h0_s4_ff;
         h1_s5_ff <= c1a_ff[L12W-1:0];
         h2_s5_ff <= c2b[L12W-1:0];
         carry_ff <= c2b[L12W+CRW-1:L12W];
      end
   end

   // stage 6: fold 5 * carry into limb 0
   logic [FW-1:0]   s0_ff;
   logic [L12W-1:0] h1_s6_ff, h2_s6_ff;

   always_ff @(posedge clock) begin
      if (stg_en[6]) begin
         s0_ff    <= FW'(h0_s5_ff) + (FW'(carry_ff) << 2) + FW'(carry_ff);
         h1_s6_ff <= h1_s5_ff;
         h2_s6_ff <= h2_s5_ff;
      end
   end

   // stage 7: final carry propagation, output register
   logic [L12W:0]     t1;
   pfsq_pkg::rsp_type rsp_in, rsp_ff;

   always_comb begin
      t1              = (L12W+1)'(h1_s6_ff) + (L12W+1)'(s0_ff[FW-1:L0W]);
      rsp_in.sq_limb0 = s0_ff[L0W-1:0];
      rsp_in.sq_limb1 = t1[L12W-1:0];
      rsp_in.sq_limb2 = L2OW'(h2_s6_ff) + L2OW'(t1[L12W]);
   end

   always_ff @(posedge clock) begin
      if (stg_en[NSTG-1]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

`ifndef SYNTHESIS
   a_reset_empties: assert property (@(posedge clock)
      reset |=> stg_valid_ff == '0)
      else $error("pipeline not empty after reset");

   a_full_backpressure: assert property (@(posedge clock) disable iff (reset)
      (&stg_valid_ff) && rsp_stall |-> req_stall)
      else $error("input taken while pipeline full and stalled");

   a_carry_bound: assert property (@(posedge clock) disable iff (reset)
      stg_valid_ff[5] |-> !carry_ff[CRW-1])
      else $error("top column carry out of range");

   a_limb2_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.sq_limb2[L2OW-1] && (|rsp_data.sq_limb2[L2OW-2:0])))
      else $error("top limb above 2^43");
`endif

endmodule

// ===== hdl/pfsq_mul.sv =====
// ----------------------------------------------------------------------------
// pfsq_mul
// Two-stage 48x48 multiplier: four registered 24x24 partial products, then
// a registered recombination truncated to the column width.
// ----------------------------------------------------------------------------
module pfsq_mul (
   input  logic                        clock,
   input  pfsq_pkg::mul_ctl_type       ctl,
   input  logic [pfsq_pkg::OP_W-1:0]   op_a,
   input  logic [pfsq_pkg::OP_W-1:0]   op_b,
   output logic [pfsq_pkg::COL_W-1:0]  prod
);

   localparam int HW  = pfsq_pkg::HALF_W;
   localparam int OPW = pfsq_pkg::OP_W;
   localparam int CW  = pfsq_pkg::COL_W;
   localparam int PPW = 2 * HW;

   logic [HW-1:0]  a_lo, a_hi, b_lo, b_hi;
   logic [PPW-1:0] pp_ll_in, pp_lh_in, pp_hl_in, pp_hh_in;
   logic [PPW-1:0] pp_ll_ff, pp_lh_ff, pp_hl_ff, pp_hh_ff;
   logic [CW-1:0]  prod_in, prod_ff;

   assign a_lo = op_a[HW-1:0];
   assign a_hi = op_a[OPW-1:HW];
   assign b_lo = op_b[HW-1:0];
   assign b_hi = op_b[OPW-1:HW];

   always_comb begin
      pp_ll_in = PPW'(a_lo) * PPW'(b_lo);
      pp_lh_in = PPW'(a_lo) * PPW'(b_hi);
      pp_hl_in = PPW'(a_hi) * PPW'(b_lo);
      pp_hh_in = PPW'(a_hi) * PPW'(b_hi);
   end

   always_ff @(posedge clock) begin
      if (ctl.pp_en) begin
         pp_ll_ff <= pp_ll_in;
         pp_lh_ff <= pp_lh_in;
         pp_hl_ff <= pp_hl_in;
         pp_hh_ff <= pp_hh_in;
      end
   end

   // true product stays below 2^92, so truncation is exact
   always_comb begin
      prod_in = CW'(pp_ll_ff)
              + (CW'(pp_lh_ff) << HW)
              + (CW'(pp_hl_ff) << HW)
              + (CW'(pp_hh_ff) << PPW);
   end

   always_ff @(posedge clock) begin
      if (ctl.sum_en) begin
         prod_ff <= prod_in;
      end
   end

   assign prod = prod_ff;

endmodule
